/* src/psm_pkg.sv */
// Shared types, codes and constants of the pump safety monitor.
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

  localparam int unsigned TIME_BITS  = 40;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned LEVEL_BITS = 16;
  localparam int unsigned RATE_BITS  = 16;
  localparam int unsigned IVAL_BITS  = 24;
  localparam int unsigned MAXL_BITS  = 15;
  // the runtime limit is the widest register
  localparam int unsigned CFG_BITS   = TIME_BITS;
  localparam int unsigned CFG_IDX_BITS = 2;

  // level change is scaled to a per-minute figure
  localparam logic [15:0] MS_PER_MIN = 16'd60000;

  localparam logic [TIME_BITS-1:0] RST_MAX_RUNTIME = TIME_BITS'(30 * 60 * 1000);
  localparam logic [RATE_BITS-1:0] RST_MAX_RATE    = RATE_BITS'(200);
  localparam logic [IVAL_BITS-1:0] RST_INTERVAL    = IVAL_BITS'(60000);
  localparam logic [MAXL_BITS-1:0] RST_MAX_LEVEL   = MAXL_BITS'(1050);

  typedef enum logic [2:0] {
    VERDICT_OK     = 3'd0,
    VERDICT_DRY    = 3'd1,
    VERDICT_OVER   = 3'd2,
    VERDICT_SENSOR = 3'd3,
    VERDICT_STUCK  = 3'd4,
    VERDICT_RAPID  = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    KIND_CHECK   = 2'd0,
    KIND_MONITOR = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ALERT_NORMAL   = 2'd0,
    ALERT_LOW      = 2'd1,
    ALERT_OVERFLOW = 2'd2,
    ALERT_OTHER    = 2'd3
  } alert_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_RUNTIME = 2'd0,
    CFG_MAX_RATE    = 2'd1,
    CFG_INTERVAL    = 2'd2,
    CFG_MAX_LEVEL   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] max_runtime;
    logic [RATE_BITS-1:0] max_rate;
    logic [IVAL_BITS-1:0] interval;
    logic [MAXL_BITS-1:0] max_level;
  } psm_cfg_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [TIME_BITS-1:0]         now_ms;
    logic                         level_valid;
    logic signed [LEVEL_BITS-1:0] level;
    logic [1:0]                   alert;
    logic                         pump_id;
    logic                         a_run;
    logic [TIME_BITS-1:0]         a_start;
    logic                         b_run;
    logic [TIME_BITS-1:0]         b_start;
  } psm_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]        dry_cnt;
    logic [COUNT_BITS-1:0]        ovf_cnt;
    logic [COUNT_BITS-1:0]        emg_cnt;
    verdict_e                     last_code;
    logic [TIME_BITS-1:0]         last_time;
    logic signed [LEVEL_BITS-1:0] ref_level;
    logic [TIME_BITS-1:0]         ref_time;
    logic                         have_ref;
  } psm_state_t;

endpackage

`default_nettype wire

/* src/psm_eval.sv */
// Per-item evaluation: verdict and next monitor state from one item.
`timescale 1ns / 1ps
`default_nettype none

module psm_eval import psm_pkg::*; (
  input  psm_cfg_t   cfg_i,
  input  psm_item_t  item_i,
  input  psm_state_t state_i,
  output psm_state_t state_o,
  output verdict_e   verdict_o
);

  logic                         healthy;
  logic [TIME_BITS-1:0]         elapsed;
  logic                         due;
  logic signed [LEVEL_BITS:0]   diff;
  logic [LEVEL_BITS:0]          diff_abs;
  logic [LEVEL_BITS-1:0]        change;
  logic [31:0]                  lhs;
  logic [TIME_BITS+RATE_BITS-1:0] rhs;
  logic                         rapid;
  logic [TIME_BITS-1:0]         run_a;
  logic [TIME_BITS-1:0]         run_b;
  logic                         stuck_a;
  logic                         stuck_b;
  logic [1:0]                   emg_inc;

  assign healthy = item_i.level_valid && !item_i.level[LEVEL_BITS-1] &&
                   (item_i.level[MAXL_BITS-1:0] <= cfg_i.max_level);

  // rate check: |dL| * 60000 > rate * elapsed, no division
  assign elapsed  = item_i.now_ms - state_i.ref_time;
  assign due      = elapsed >= {{(TIME_BITS-IVAL_BITS){1'b0}}, cfg_i.interval};
  assign diff     = {item_i.level[LEVEL_BITS-1], item_i.level} -
                    {state_i.ref_level[LEVEL_BITS-1], state_i.ref_level};
  assign diff_abs = diff[LEVEL_BITS] ? (~diff + 1'b1) : diff;
  assign change   = diff_abs[LEVEL_BITS-1:0];
  assign lhs      = 32'(change) * 32'(MS_PER_MIN);
  assign rhs      = (TIME_BITS+RATE_BITS)'(cfg_i.max_rate) *
                    (TIME_BITS+RATE_BITS)'(elapsed);
  assign rapid    = {{(TIME_BITS+RATE_BITS-32){1'b0}}, lhs} > rhs;

  // start time of zero means unknown and is never checked
  assign run_a   = item_i.now_ms - item_i.a_start;
  assign run_b   = item_i.now_ms - item_i.b_start;
  assign stuck_a = item_i.a_run && (item_i.a_start != '0) && (run_a > cfg_i.max_runtime);
  assign stuck_b = item_i.b_run && (item_i.b_start != '0) && (run_b > cfg_i.max_runtime);

  always_comb begin
    emg_inc = 2'(stuck_a) + 2'(stuck_b) +
              2'(!healthy && (item_i.a_run || item_i.b_run));
  end

  always_comb begin
    state_o   = state_i;
    verdict_o = VERDICT_OK;
    case (kind_e'(item_i.kind))
      KIND_CHECK: begin
        if (!healthy) begin
          verdict_o = VERDICT_SENSOR;
        end else if (alert_e'(item_i.alert) == ALERT_LOW) begin
          state_o.dry_cnt   = state_i.dry_cnt + 1'b1;
          state_o.last_code = VERDICT_DRY;
          state_o.last_time = item_i.now_ms;
          verdict_o         = VERDICT_DRY;
        end else if (alert_e'(item_i.alert) == ALERT_OVERFLOW) begin
          state_o.ovf_cnt   = state_i.ovf_cnt + 1'b1;
          state_o.last_code = VERDICT_OVER;
          state_o.last_time = item_i.now_ms;
          verdict_o         = VERDICT_OVER;
        end
      end
      KIND_MONITOR: begin
        state_o.emg_cnt = state_i.emg_cnt + COUNT_BITS'(emg_inc);
        if (!healthy) begin
          verdict_o = VERDICT_SENSOR;
        end
        if (item_i.level_valid && (!state_i.have_ref || due)) begin
          state_o.ref_level = item_i.level;
          state_o.ref_time  = item_i.now_ms;
          state_o.have_ref  = 1'b1;
        end
        if (item_i.level_valid && state_i.have_ref && due && rapid) begin
          state_o.last_code = VERDICT_RAPID;
          state_o.last_time = item_i.now_ms;
          verdict_o         = VERDICT_RAPID;
        end
        if (stuck_a || stuck_b) begin
          state_o.last_code = VERDICT_STUCK;
          state_o.last_time = item_i.now_ms;
          verdict_o         = VERDICT_STUCK;
        end
      end
      KIND_CLEAR: begin
        // rate reference survives a clear
        state_o.dry_cnt   = '0;
        state_o.ovf_cnt   = '0;
        state_o.emg_cnt   = '0;
        state_o.last_code = VERDICT_OK;
        state_o.last_time = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/pump_safety_monitor.sv */
// Pump safety monitor top level: config registers, item pipeline, state.
// An accepted item enters the input register; its result is then held in
// the result register. Throughput: one item per cycle unless out_ready_i
// stalls; each item is evaluated in one pass between the two registers.
// Reset clears the counters, latest violation and rate reference and
// loads the default limits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module pump_safety_monitor import psm_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  wire logic [CFG_BITS-1:0]          cfg_wdata_i,

  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   kind_i,
  input  wire logic [TIME_BITS-1:0]         now_ms_i,
  input  wire logic                         level_valid_i,
  input  wire logic signed [LEVEL_BITS-1:0] level_percent_i,
  input  wire logic [1:0]                   level_alert_i,
  input  wire logic                         pump_id_i,
  input  wire logic                         pump_a_running_i,
  input  wire logic [TIME_BITS-1:0]         pump_a_start_ms_i,
  input  wire logic                         pump_b_running_i,
  input  wire logic [TIME_BITS-1:0]         pump_b_start_ms_i,

  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [2:0]                        verdict_o,
  output logic [COUNT_BITS-1:0]             dry_run_total_o,
  output logic [COUNT_BITS-1:0]             overflow_total_o,
  output logic [COUNT_BITS-1:0]             emergency_total_o,
  output logic [2:0]                        latest_violation_o,
  output logic [TIME_BITS-1:0]              latest_violation_ms_o
);

  psm_cfg_t   cfg_q;
  psm_item_t  item_q, item_d;
  logic       item_vld_q;
  psm_state_t state_q, state_d;
  verdict_e   verdict_d, verdict_q;
  logic       out_vld_q;
  logic       advance;

  // result register frees up when empty or taken this cycle
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_runtime <= RST_MAX_RUNTIME;
      cfg_q.max_rate    <= RST_MAX_RATE;
      cfg_q.interval    <= RST_INTERVAL;
      cfg_q.max_level   <= RST_MAX_LEVEL;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_RUNTIME: cfg_q.max_runtime <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_MAX_RATE:    cfg_q.max_rate    <= cfg_wdata_i[RATE_BITS-1:0];
        CFG_INTERVAL:    cfg_q.interval    <= cfg_wdata_i[IVAL_BITS-1:0];
        CFG_MAX_LEVEL:   cfg_q.max_level   <= cfg_wdata_i[MAXL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item_d.kind        = kind_i;
    item_d.now_ms      = now_ms_i;
    item_d.level_valid = level_valid_i;
    item_d.level       = level_percent_i;
    item_d.alert       = level_alert_i;
    item_d.pump_id     = pump_id_i;
    item_d.a_run       = pump_a_running_i;
    item_d.a_start     = pump_a_start_ms_i;
    item_d.b_run       = pump_b_running_i;
    item_d.b_start     = pump_b_start_ms_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  psm_eval u_eval (
    .cfg_i     (cfg_q),
    .item_i    (item_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .verdict_o (verdict_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= item_vld_q;
      if (item_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_vld_q) begin
      verdict_q <= verdict_d;
    end
  end

  // counters and latest violation are read straight from the state
  assign out_valid_o           = out_vld_q;
  assign verdict_o             = verdict_q;
  assign dry_run_total_o       = state_q.dry_cnt;
  assign overflow_total_o      = state_q.ovf_cnt;
  assign emergency_total_o     = state_q.emg_cnt;
  assign latest_violation_o    = state_q.last_code;
  assign latest_violation_ms_o = state_q.last_time;

  // state only moves when an item is evaluated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && item_vld_q) |=> $stable(state_q))
    else $error("monitor state changed without an item");

  // a clear item leaves all counters at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_vld_q && kind_e'(item_q.kind) == KIND_CLEAR) |=>
      (state_q.dry_cnt == '0 && state_q.ovf_cnt == '0 && state_q.emg_cnt == '0))
    else $error("clear item left a counter nonzero");

  // once a rate reference exists it is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.have_ref |=> state_q.have_ref)
    else $error("rate reference lost");

  // stuck and rapid verdicts are always the recorded violation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (verdict_q == VERDICT_STUCK || verdict_q == VERDICT_RAPID)) |->
      (state_q.last_code == verdict_q))
    else $error("verdict not recorded as latest violation");

endmodule

`default_nettype wire
